[rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// shared types, action codes and defaults for the circular deque
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int WORD_W            = 32;
	localparam int CAP_W             = 5;
	localparam int ACT_W             = 3;
	localparam int DEFAULT_MAX_DEPTH = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [WORD_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic                     accepted;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] rear_value;
		logic                     is_empty;
		logic                     is_full;
	} rsp_t;

	// status of the last operation, from pointer logic to the sequencer
	typedef struct packed {
		logic ok;
		logic empty;
		logic full;
	} ptr_stat_t;

endpackage

[rtl/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/cdq_ptr.sv]
// ----------------------------------------------------------------------------
// cdq_ptr
// head, tail and count registers with the refuse logic of each action
// ----------------------------------------------------------------------------
module cdq_ptr
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [ACT_W-1:0]             action,
	input  logic [CAP_W-1:0]             capacity,
	output logic                         wr_en,
	output logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
	output logic [$clog2(MAX_DEPTH)-1:0] head_addr,
	output logic [$clog2(MAX_DEPTH)-1:0] rear_addr,
	output ptr_stat_t                    stat
);

	localparam int AW   = $clog2(MAX_DEPTH);
	localparam int CW   = $clog2(MAX_DEPTH + 1);
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [AW-1:0]   LAST_SLOT = AW'(MAX_DEPTH - 1);
	localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(MAX_DEPTH);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	ptr_stat_t     stat_q;

	logic [AW-1:0]   head_prev, head_next, tail_prev, tail_next;
	logic [CMPW-1:0] cap_cmp, eff_cap, count_cmp, new_count_cmp;
	logic [CW-1:0]   new_count;
	logic [AW-1:0]   new_head, new_tail;
	logic            cur_full, cur_empty, ok;

	assign head_prev = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
	assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_SLOT : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;

	// capacity above the ring size is clamped
	assign cap_cmp   = CMPW'(capacity);
	assign eff_cap   = (cap_cmp > DEPTH_CMP) ? DEPTH_CMP : cap_cmp;
	assign count_cmp = CMPW'(count_q);
	assign cur_full  = (count_cmp >= eff_cap);
	assign cur_empty = (count_q == '0);

	always_comb begin
		ok        = 1'b1;
		new_head  = head_q;
		new_tail  = tail_q;
		new_count = count_q;
		case (action)
			ACT_PUSH_FRONT: begin
				if (cur_full) begin
					ok = 1'b0;
				end else begin
					new_head  = head_prev;
					new_count = count_q + 1'b1;
				end
			end
			ACT_PUSH_REAR: begin
				if (cur_full) begin
					ok = 1'b0;
				end else begin
					new_tail  = tail_next;
					new_count = count_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (cur_empty) begin
					ok = 1'b0;
				end else begin
					new_head  = head_next;
					new_count = count_q - 1'b1;
				end
			end
			ACT_POP_REAR: begin
				if (cur_empty) begin
					ok = 1'b0;
				end else begin
					new_tail  = tail_prev;
					new_count = count_q - 1'b1;
				end
			end
			default: begin
				// query and unknown codes leave the state alone
				ok = 1'b1;
			end
		endcase
	end

	assign new_count_cmp = CMPW'(new_count);

	assign wr_en   = take && !cur_full &&
		((action == ACT_PUSH_FRONT) || (action == ACT_PUSH_REAR));
	assign wr_addr = (action == ACT_PUSH_FRONT) ? head_prev : tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			stat_q  <= '0;
		end else if (take) begin
			head_q       <= new_head;
			tail_q       <= new_tail;
			count_q      <= new_count;
			stat_q.ok    <= ok;
			stat_q.empty <= (new_count == '0);
			stat_q.full  <= (new_count_cmp >= eff_cap);
		end
	end

	assign head_addr = head_q;
	assign rear_addr = tail_prev;
	assign stat      = stat_q;

endmodule

[rtl/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// bounded double-ended queue of signed words held in a ring memory
// result strobe follows the start transfer through states ST_RDF, ST_RDR and ST_RESP
// a new operation is held off (busy) while two reads of one ram port run
// (front entry, then rear entry) after the pointer update; one is taken again in the result state
// reset: empty deque, capacity 16; ram contents are not cleared
// the receiver cannot stall: a result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module circular_deque_unit
	import cdq_pkg::*;
#(
	parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cmd_t             cmd,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             result
);

	localparam int AW = $clog2(MAX_DEPTH);

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RDF  = 4'b0010,
		ST_RDR  = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic              take;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, head_addr, rear_addr, rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] front_q;
	ptr_stat_t         stat;

	// capacity register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// a new command may be taken in the result cycle: the result is built
	// from registers that are sampled at that same edge
	assign busy = (state_q == ST_RDF) || (state_q == ST_RDR);
	assign take = start && !busy;

	// pointer update and push write both happen at the start transfer
	cdq_ptr #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_ptr (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.action    (cmd.action),
		.capacity  (cap_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.head_addr (head_addr),
		.rear_addr (rear_addr),
		.stat      (stat)
	);

	// reads begin in ST_RDF, after the write has landed in the ram, so no forwarding is needed
	assign rd_addr = (state_q == ST_RDF) ? head_addr : rear_addr;

	cdq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (cmd.push_value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = ST_RDF;
				end
			end
			ST_RDF: begin
				state_d = ST_RDR;
			end
			ST_RDR: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = take ? ST_RDF : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// front entry arrives while the rear read is issued
	always_ff @(posedge clk) begin
		if (state_q == ST_RDR) begin
			front_q <= rd_data;
		end
	end

	// result cycle: rear entry straight from the ram output register
	assign done               = (state_q == ST_RESP);
	assign result.accepted    = stat.ok;
	assign result.front_value = stat.empty ? EMPTY_WORD : front_q;
	assign result.rear_value  = stat.empty ? EMPTY_WORD : rd_data;
	assign result.is_empty    = stat.empty;
	assign result.is_full     = stat.full;

`ifndef ASSERT_OFF
	a_take_starts_read : assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == ST_RDF))
		else $error("start transfer did not begin the front read");

	a_done_after_reads : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy, 1) && $past(busy, 2)))
		else $error("result strobe without both ram reads");

	a_empty_masks : assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
			((result.front_value == EMPTY_WORD) && (result.rear_value == EMPTY_WORD)))
		else $error("empty deque shows stored words");

	a_busy_no_strobe : assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while reads are in flight");
`endif

endmodule

[tb/circular_deque_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_checker
// watches the command, config and result channels of the circular deque,
// keeps its own copy of the ring and flags any result that differs
// ----------------------------------------------------------------------------
module circular_deque_checker
	import cdq_pkg::*;
#(
	parameter int DEPTH      = DEFAULT_MAX_DEPTH,
	parameter int REPORT_CAP = 200
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  cmd_t             cmd,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             done,
	input  rsp_t             result,
	output int               fail_count,
	output int               outstanding
);

	logic signed [WORD_W-1:0] ring [DEPTH];
	int                       head;
	int                       tail;
	int                       fill;
	logic [CAP_W-1:0]         cap_reg;
	rsp_t                     status_due_q [$];

	function automatic int step_back(input int idx);
		return (idx == 0) ? DEPTH - 1 : idx - 1;
	endfunction

	function automatic int step_fwd(input int idx);
		return (idx == DEPTH - 1) ? 0 : idx + 1;
	endfunction

	// applies one operation to the local ring and returns the status after it
	function automatic rsp_t predict_deque_op(input cmd_t c);
		rsp_t st;
		int   lim;
		lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		st.accepted = 1'b1;
		case (c.action)
			ACT_PUSH_FRONT: begin
				if (fill >= lim) begin
					st.accepted = 1'b0;
				end else begin
					head = step_back(head);
					ring[head] = c.push_value;
					fill++;
				end
			end
			ACT_PUSH_REAR: begin
				if (fill >= lim) begin
					st.accepted = 1'b0;
				end else begin
					ring[tail] = c.push_value;
					tail = step_fwd(tail);
					fill++;
				end
			end
			ACT_POP_FRONT: begin
				if (fill == 0) begin
					st.accepted = 1'b0;
				end else begin
					head = step_fwd(head);
					fill--;
				end
			end
			ACT_POP_REAR: begin
				if (fill == 0) begin
					st.accepted = 1'b0;
				end else begin
					tail = step_back(tail);
					fill--;
				end
			end
			default: begin
			end
		endcase
		st.is_empty    = (fill == 0);
		st.is_full     = (fill >= lim);
		st.front_value = st.is_empty ? EMPTY_WORD : ring[head];
		st.rear_value  = st.is_empty ? EMPTY_WORD : ring[step_back(tail)];
		return st;
	endfunction

	task automatic flag(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		fail_count++;
		if (fail_count <= REPORT_CAP) begin
			$display("%0t %s mismatch: expected %0d (%h), actual %0d (%h)",
				$time, what, $signed(want), want, $signed(got), got);
		end
	endtask

	task automatic compare_status(input rsp_t got);
		rsp_t want;
		if (status_due_q.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_CAP) begin
				$display("%0t stray result: expected none, actual %h", $time, got);
			end
		end else begin
			want = status_due_q.pop_front();
			if (got.accepted !== want.accepted) begin
				flag("accepted", want.accepted, got.accepted);
			end
			if (got.front_value !== want.front_value) begin
				flag("front_value", want.front_value, got.front_value);
			end
			if (got.rear_value !== want.rear_value) begin
				flag("rear_value", want.rear_value, got.rear_value);
			end
			if (got.is_empty !== want.is_empty) begin
				flag("is_empty", want.is_empty, got.is_empty);
			end
			if (got.is_full !== want.is_full) begin
				flag("is_full", want.is_full, got.is_full);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head        = 0;
			tail        = 0;
			fill        = 0;
			cap_reg     = CAP_RESET;
			fail_count  = 0;
			outstanding = 0;
			status_due_q.delete();
		end else begin
			// results first: a result never belongs to a transfer of the same edge
			if (done) begin
				compare_status(result);
			end
			if (start && !busy) begin
				status_due_q.push_back(predict_deque_op(cmd));
			end
			if (cfg_we) begin
				cap_reg = cfg_wdata;
			end
			outstanding = status_due_q.size();
		end
	end

endmodule

[tb/tb_circular_deque_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque_unit
// drives deque operations and capacity changes into the circular deque and
// lets a side checker compare every result against its own model of the ring
// ----------------------------------------------------------------------------
module tb_circular_deque_unit
	import cdq_pkg::*;
();

	localparam int ITEMS_PER_PHASE = 100;
	localparam int RUN_LIMIT       = 250000;   // cycles, far above the slowest run
	localparam int SETTLE_CYCLES   = 8;        // margin above the result latency

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             done;
	rsp_t             result;
	int               fail_count;
	int               outstanding;
	int               cycle_count = 0;
	int               calm_left   = 0;   // transfers left in a stretch without gaps

	circular_deque_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	circular_deque_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog: a hung handshake or a missing result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// push data: mostly random, now and then the corner words
	function automatic logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return EMPTY_WORD;                    // same bits as the empty marker
			2:       return {1'b1, {(WORD_W-1){1'b0}}};    // most negative
			3:       return {1'b0, {(WORD_W-1){1'b1}}};    // most positive
			default: return $urandom;
		endcase
	endfunction

	// one command transfer; called and left at a falling edge
	// start is only lowered when a gap follows, so it never gets two
	// assignments in the same time step
	task automatic send_op(input logic [ACT_W-1:0] act, input logic signed [WORD_W-1:0] word);
		cmd_t c;
		cmd_t junk;
		int   gap;
		int   r;
		c.action     = act;
		c.push_value = word;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
		// gap length: long calm stretches, otherwise mostly short with the odd long one
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				calm_left = $urandom_range(10, 40);
			end
			gap = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		end
		if (gap > 0) begin
			// idle bus carries rubbish, the block must ignore it
			junk.action     = ACT_W'($urandom);
			junk.push_value = $urandom;
			start <= 1'b0;
			cmd   <= junk;
			repeat (gap) @(negedge clk);
		end
	endtask

	// wait until every result is in, then let the pipeline go quiet
	task automatic drain();
		start <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// capacity writes only happen with the block idle
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(negedge clk);
	endtask

	// a phase of random operations; the push/pop mix steers the fill level
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int push_pct, input int pop_pct);
		logic [ACT_W-1:0] act;
		int               r;
		set_capacity(cap);
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
			end else if (r < push_pct + pop_pct) begin
				act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
			end else begin
				// plain query or one of the undefined codes
				act = ACT_W'($urandom_range(int'(ACT_QUERY), (1 << ACT_W) - 1));
			end
			send_op(act, rand_word());
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = CAP_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty deque straight out of reset, capacity at its reset value
		send_op(ACT_QUERY, rand_word());
		send_op(ACT_POP_FRONT, rand_word());                      // refused, empty
		send_op(ACT_POP_REAR, rand_word());                       // refused, empty
		send_op(ACT_PUSH_FRONT, {1'b0, {(WORD_W-1){1'b1}}});      // head wraps below slot 0
		send_op(ACT_PUSH_REAR, {1'b1, {(WORD_W-1){1'b0}}});
		send_op(ACT_PUSH_FRONT, '0);
		send_op(ACT_PUSH_REAR, EMPTY_WORD);                       // stored word equal to the marker
		send_op(ACT_W'(5), rand_word());                          // undefined codes act as a query
		send_op(ACT_W'(6), rand_word());
		send_op(ACT_W'(7), rand_word());
		send_op(ACT_POP_FRONT, rand_word());
		send_op(ACT_POP_REAR, rand_word());
		send_op(ACT_POP_REAR, rand_word());
		send_op(ACT_POP_FRONT, rand_word());                      // back to empty

		// small capacity: fill it, then a refused push
		set_capacity(5'd2);
		send_op(ACT_PUSH_REAR, $urandom);
		send_op(ACT_PUSH_REAR, $urandom);
		send_op(ACT_PUSH_FRONT, $urandom);                        // refused, full
		send_op(ACT_QUERY, rand_word());

		// capacity below the count: entries kept, still reads full
		set_capacity(5'd1);
		send_op(ACT_PUSH_FRONT, $urandom);                        // refused
		send_op(ACT_POP_FRONT, rand_word());
		send_op(ACT_POP_REAR, rand_word());

		// zero capacity: empty and full together, nothing fits
		set_capacity(5'd0);
		send_op(ACT_PUSH_REAR, $urandom);
		send_op(ACT_QUERY, rand_word());

		// random phases, ordered so that one capacity often lands under the
		// fill level the phase before left behind
		run_phase(5'd16, 70, 20);                                 // fill up to the ring size
		run_phase(5'd3, 25, 60);                                  // starts over capacity, drains
		run_phase(5'd0, 45, 45);
		run_phase(5'd31, 70, 20);                                 // above the ring size, clamped
		run_phase(5'd1, 45, 45);
		run_phase(5'd24, 50, 40);
		run_phase(5'd8, 25, 65);
		run_phase(CAP_W'($urandom), 45, 45);

		drain();
		if (fail_count == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
